[rtl/scp_pkg.sv]
// ---------------------------------------------------------------------------
// scp_pkg: shared definitions for the console command-line parser
// Line store geometry, character codes, command codes, the job record that
// travels from the front end to the checker, and small character helpers.
// ---------------------------------------------------------------------------
package scp_pkg;

   localparam int LineBytes   = 64;
   localparam int IdDigits    = 16;
   localparam int AddrW       = $clog2(LineBytes);
   localparam int IdBits      = IdDigits * 4;
   localparam int DevIdW      = 64;
   localparam int PrefixW     = 64;
   localparam int PrefixLenW  = 4;
   localparam int QueueDepth  = 4;
   localparam int QPtrW       = $clog2(QueueDepth);

   localparam logic [7:0] ChSpace    = 8'h20;
   localparam logic [7:0] ChMaxPrint = 8'h7e;
   localparam logic [7:0] ChCr       = 8'h0d;
   localparam logic [7:0] ChLf       = 8'h0a;
   localparam logic [7:0] ChZero     = 8'h30;
   localparam logic [7:0] ChNine     = 8'h39;
   localparam logic [7:0] ChLowA     = 8'h61;
   localparam logic [7:0] ChLowF     = 8'h66;

   localparam logic [1:0] CmdStatus  = 2'd0;
   localparam logic [1:0] CmdKey     = 2'd1;
   localparam logic [1:0] CmdLock    = 2'd2;

   localparam logic [AddrW-1:0] LenStatus = AddrW'(6);
   localparam logic [AddrW-1:0] LenKey    = AddrW'(3);
   localparam logic [AddrW-1:0] LenLock   = AddrW'(4);

   // One entry per accepted byte; only an end of line that was not discarded
   // asks the checker to scan the store.
   typedef struct packed {
      logic             is_check;
      logic [AddrW-1:0] fill;
   } job_type;

   function automatic logic [7:0] status_char(input logic [2:0] j);
      logic [7:0] c;
      unique case (j)
         3'd0:    c = 8'h53; // S
         3'd1:    c = 8'h54; // T
         3'd2:    c = 8'h41; // A
         3'd3:    c = 8'h54; // T
         3'd4:    c = 8'h55; // U
         3'd5:    c = 8'h53; // S
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] key_char(input logic [2:0] j);
      logic [7:0] c;
      unique case (j)
         3'd0:    c = 8'h4b; // K
         3'd1:    c = 8'h45; // E
         3'd2:    c = 8'h59; // Y
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] lock_char(input logic [2:0] j);
      logic [7:0] c;
      unique case (j)
         3'd0:    c = 8'h4c; // L
         3'd1:    c = 8'h4f; // O
         3'd2:    c = 8'h43; // C
         3'd3:    c = 8'h4b; // K
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= ChZero) && (c <= ChNine)) || ((c >= ChLowA) && (c <= ChLowF));
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c <= ChNine) begin
         v = c - ChZero;
      end else begin
         v = c - ChLowA + 8'd10;
      end
      return v[3:0];
   endfunction

endpackage

[rtl/setup_command_line_parser_top.sv]
// ---------------------------------------------------------------------------
// setup_command_line_parser_top: console command-line recognizer
// Gathers console bytes into a line store and, on each line feed, checks the
// line for "<prefix> <hex id> <STATUS|KEY|LOCK>".
//
// Usage: bytes enter through a queue-style port (req_push / req_full) and
// every byte yields exactly one result transaction on the response port
// (rsp_empty / rsp_pop), in order. The result flags a well-formed command
// line on the line feed that ends it; all other results carry zeros.
// The prefix registers are written through csr_wr_en / csr_index / csr_wdata
// while the block is idle, a rule for the user that the block does not enforce.
// An ordinary byte reaches the response port through the job queue and the
// result register, one byte per cycle sustained while req_full stays low.
// A line feed starts a scan of the line store through its single read port,
// one stored byte per cycle, and req_full stays high until the check ends.
// A stalled consumer fills the four-entry job queue, then req_full rises.
// Reset empties the line, the queue and the result register and sets the
// prefix to a single zero character.
// ---------------------------------------------------------------------------
module setup_command_line_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_rx_byte,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_request_valid,
   output logic [1:0]  rsp_command_code,
   output logic [63:0] rsp_device_id,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   localparam logic CsrPrefixChars  = 1'b0;
   localparam logic CsrPrefixLength = 1'b1;

   logic [scp_pkg::PrefixW-1:0]    prefix_chars_ff;
   logic [scp_pkg::PrefixLenW-1:0] pfx_len_ff;

   scp_pkg::job_type          fq_push_data;
   scp_pkg::job_type          fq_pop_data;
   logic                      fq_push;
   logic                      fq_pop;
   logic                      fq_full;
   logic                      fq_empty;
   logic                      wr_en;
   logic [scp_pkg::AddrW-1:0] wr_addr;
   logic [7:0]                wr_data;
   logic                      rd_en;
   logic [scp_pkg::AddrW-1:0] rd_addr;
   logic [7:0]                rd_data;
   logic                      check_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_chars_ff <= '0;
         pfx_len_ff      <= scp_pkg::PrefixLenW'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrPrefixChars:  prefix_chars_ff <= csr_wdata;
            CsrPrefixLength: pfx_len_ff      <= csr_wdata[scp_pkg::PrefixLenW-1:0];
            default:         prefix_chars_ff <= prefix_chars_ff;
         endcase
      end
   end

   scp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_rx_byte (req_rx_byte),
      .req_full    (req_full),
      .job_full    (fq_full),
      .job_push    (fq_push),
      .job_data    (fq_push_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .check_done  (check_done)
   );

   scp_ram #(
      .WIDTH (8),
      .DEPTH (scp_pkg::LineBytes)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   scp_fifo u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_push_data),
      .full      (fq_full),
      .pop       (fq_pop),
      .pop_data  (fq_pop_data),
      .empty     (fq_empty)
   );

   scp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_empty         (fq_empty),
      .job_data          (fq_pop_data),
      .job_pop           (fq_pop),
      .prefix_chars      (prefix_chars_ff),
      .pfx_len           (pfx_len_ff),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .check_done        (check_done),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_request_valid (rsp_request_valid),
      .rsp_command_code  (rsp_command_code),
      .rsp_device_id     (rsp_device_id)
   );

   // A finished line check always happens while intake is held off.
   a_check_while_held: assert property (@(posedge clock) disable iff (reset)
      check_done |-> req_full)
      else $error("line check finished while intake was open");

   // The line store is never written while the checker reads it.
   a_no_write_during_scan: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !wr_en)
      else $error("line store written during a scan");

   // A result without a request carries all-zero fields.
   a_zero_when_no_request: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_request_valid) |->
         (rsp_command_code == scp_pkg::CmdStatus) && (rsp_device_id == '0))
      else $error("non-request result has nonzero fields");

   // A request names one of the three defined commands.
   a_code_defined: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_request_valid) |->
         (rsp_command_code == scp_pkg::CmdStatus) ||
         (rsp_command_code == scp_pkg::CmdKey) ||
         (rsp_command_code == scp_pkg::CmdLock))
      else $error("request with undefined command code");

endmodule

[rtl/scp_ram.sv]
// ---------------------------------------------------------------------------
// scp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module scp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/scp_front.sv]
// ---------------------------------------------------------------------------
// scp_front: byte intake and classification
// Stores printable bytes and carriage returns into the line store, tracks the
// fill and discard mark, and queues one job per byte for the checker.
// ---------------------------------------------------------------------------
module scp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  logic [7:0]              req_rx_byte,
   output logic                    req_full,
   input  logic                    job_full,
   output logic                    job_push,
   output scp_pkg::job_type        job_data,
   output logic                    wr_en,
   output logic [scp_pkg::AddrW-1:0] wr_addr,
   output logic [7:0]              wr_data,
   input  logic                    check_done
);

   logic [scp_pkg::AddrW-1:0] fill_ff, fill_in;
   logic                      disc_ff, disc_in;
   logic                      last_cr_ff, last_cr_in;
   logic                      chk_pend_ff, chk_pend_in;
   logic                      accept;
   logic                      bad_byte;

   // The store must not change under the checker, so intake holds while a
   // line check is queued or running.
   assign req_full = job_full | chk_pend_ff;
   assign accept   = req_push & ~req_full;

   assign bad_byte = ((req_rx_byte < scp_pkg::ChSpace) && (req_rx_byte != scp_pkg::ChCr)) ||
                     (req_rx_byte > scp_pkg::ChMaxPrint) ||
                     (fill_ff >= scp_pkg::AddrW'(scp_pkg::LineBytes - 1));

   always_comb begin
      fill_in          = fill_ff;
      disc_in          = disc_ff;
      last_cr_in       = last_cr_ff;
      chk_pend_in      = chk_pend_ff;
      job_push         = 1'b0;
      job_data.is_check = 1'b0;
      job_data.fill    = fill_ff;
      wr_en            = 1'b0;
      wr_addr          = fill_ff;
      wr_data          = req_rx_byte;
      if (check_done) begin
         chk_pend_in = 1'b0;
      end
      if (accept) begin
         job_push = 1'b1;
         if (req_rx_byte == scp_pkg::ChLf) begin
            job_data.is_check = ~disc_ff;
            // A trailing CR is dropped from the checked length.
            if (last_cr_ff) begin
               job_data.fill = fill_ff - scp_pkg::AddrW'(1);
            end
            chk_pend_in = ~disc_ff;
            disc_in     = 1'b0;
            fill_in     = '0;
            last_cr_in  = 1'b0;
         end else if (!disc_ff) begin
            if (bad_byte) begin
               disc_in = 1'b1;
            end else begin
               wr_en      = 1'b1;
               fill_in    = fill_ff + scp_pkg::AddrW'(1);
               last_cr_in = (req_rx_byte == scp_pkg::ChCr);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         disc_ff     <= 1'b0;
         last_cr_ff  <= 1'b0;
         chk_pend_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         disc_ff     <= disc_in;
         last_cr_ff  <= last_cr_in;
         chk_pend_ff <= chk_pend_in;
      end
   end

endmodule

[rtl/scp_fifo.sv]
// ---------------------------------------------------------------------------
// scp_fifo: short job queue between front end and checker
// A small register queue that lets intake and checking stall separately.
// ---------------------------------------------------------------------------
module scp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  scp_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output scp_pkg::job_type pop_data,
   output logic             empty
);

   scp_pkg::job_type          slot_ff [scp_pkg::QueueDepth];
   logic [scp_pkg::QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [scp_pkg::QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [scp_pkg::QPtrW:0]   count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full     = (count_ff == (scp_pkg::QPtrW + 1)'(scp_pkg::QueueDepth));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + scp_pkg::QPtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + scp_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (scp_pkg::QPtrW + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (scp_pkg::QPtrW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/scp_back.sv]
// ---------------------------------------------------------------------------
// scp_back: line checker and result register
// Takes jobs from the queue, scans a finished line one byte per cycle out of
// the line store, and holds one result for the consumer.
// ---------------------------------------------------------------------------
module scp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_empty,
   input  scp_pkg::job_type              job_data,
   output logic                          job_pop,
   input  logic [scp_pkg::PrefixW-1:0]   prefix_chars,
   input  logic [scp_pkg::PrefixLenW-1:0] pfx_len,
   output logic                          rd_en,
   output logic [scp_pkg::AddrW-1:0]     rd_addr,
   input  logic [7:0]                    rd_data,
   output logic                          check_done,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_request_valid,
   output logic [1:0]                    rsp_command_code,
   output logic [scp_pkg::DevIdW-1:0]    rsp_device_id
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type                  state_ff, state_in;
   logic [scp_pkg::AddrW-1:0]  fill_ff, fill_in;
   logic [scp_pkg::AddrW-1:0]  rd_idx_ff, rd_idx_in;
   logic                       dv_ff, dv_in;
   logic [scp_pkg::AddrW-1:0]  didx_ff, didx_in;
   logic                       match_ff, match_in;
   logic                       st_ok_ff, st_ok_in;
   logic                       key_ok_ff, key_ok_in;
   logic                       lock_ok_ff, lock_ok_in;
   logic [scp_pkg::IdBits-1:0] acc_ff, acc_in;
   logic                       out_vld_ff, out_vld_in;
   logic                       out_req_ff, out_req_in;
   logic [1:0]                 out_code_ff, out_code_in;
   logic [scp_pkg::DevIdW-1:0] out_id_ff, out_id_in;

   logic [scp_pkg::PrefixLenW-1:0] nlen;
   logic [scp_pkg::AddrW-1:0]      off;
   logic [scp_pkg::AddrW-1:0]      tail_j;
   logic [scp_pkg::AddrW-1:0]      tlen;
   logic [7:0]                     pfx_char;
   logic                           out_free;
   logic                           ok_st, ok_key, ok_lock;

   assign nlen = (pfx_len == '0) ? scp_pkg::PrefixLenW'(1) :
                 (pfx_len > scp_pkg::PrefixLenW'(8)) ? scp_pkg::PrefixLenW'(8) :
                 pfx_len;
   // Command word starts after prefix, space, identifier digits and space.
   assign off      = scp_pkg::AddrW'(nlen) + scp_pkg::AddrW'(scp_pkg::IdDigits + 2);
   assign tail_j   = didx_ff - off;
   assign tlen     = fill_ff - off;
   assign pfx_char = prefix_chars[{didx_ff[2:0], 3'b000} +: 8];
   assign out_free = ~out_vld_ff | rsp_pop;

   assign ok_st   = match_ff & st_ok_ff & (tlen == scp_pkg::LenStatus);
   assign ok_key  = match_ff & key_ok_ff & (tlen == scp_pkg::LenKey);
   assign ok_lock = match_ff & lock_ok_ff & (tlen == scp_pkg::LenLock);

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      rd_idx_in   = rd_idx_ff;
      dv_in       = 1'b0;
      didx_in     = rd_idx_ff;
      match_in    = match_ff;
      st_ok_in    = st_ok_ff;
      key_ok_in   = key_ok_ff;
      lock_ok_in  = lock_ok_ff;
      acc_in      = acc_ff;
      out_vld_in  = out_vld_ff & ~rsp_pop;
      out_req_in  = out_req_ff;
      out_code_in = out_code_ff;
      out_id_in   = out_id_ff;
      job_pop     = 1'b0;
      check_done  = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = rd_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!job_empty && out_free) begin
               job_pop = 1'b1;
               if (job_data.is_check && (job_data.fill > off)) begin
                  fill_in    = job_data.fill;
                  rd_idx_in  = '0;
                  match_in   = 1'b1;
                  st_ok_in   = 1'b1;
                  key_ok_in  = 1'b1;
                  lock_ok_in = 1'b1;
                  acc_in     = '0;
                  state_in   = ST_SCAN;
               end else begin
                  // A plain byte, or a line too short to hold a command.
                  out_vld_in  = 1'b1;
                  out_req_in  = 1'b0;
                  out_code_in = scp_pkg::CmdStatus;
                  out_id_in   = '0;
                  check_done  = job_data.is_check;
               end
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff != fill_ff) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + scp_pkg::AddrW'(1);
               dv_in     = 1'b1;
            end
            if (dv_ff) begin
               if (didx_ff < scp_pkg::AddrW'(nlen)) begin
                  match_in = match_ff & (rd_data == pfx_char);
               end else if (didx_ff == scp_pkg::AddrW'(nlen)) begin
                  match_in = match_ff & (rd_data == scp_pkg::ChSpace);
               end else if (didx_ff < off - scp_pkg::AddrW'(1)) begin
                  match_in = match_ff & scp_pkg::is_hex(rd_data);
                  acc_in   = (acc_ff << 4) |
                             scp_pkg::IdBits'(scp_pkg::hex_value(rd_data));
               end else if (didx_ff == off - scp_pkg::AddrW'(1)) begin
                  match_in = match_ff & (rd_data == scp_pkg::ChSpace);
               end else begin
                  st_ok_in   = st_ok_ff & (tail_j < scp_pkg::LenStatus) &
                               (rd_data == scp_pkg::status_char(tail_j[2:0]));
                  key_ok_in  = key_ok_ff & (tail_j < scp_pkg::LenKey) &
                               (rd_data == scp_pkg::key_char(tail_j[2:0]));
                  lock_ok_in = lock_ok_ff & (tail_j < scp_pkg::LenLock) &
                               (rd_data == scp_pkg::lock_char(tail_j[2:0]));
               end
            end
            if ((rd_idx_ff == fill_ff) && !dv_ff && out_free) begin
               out_vld_in = 1'b1;
               out_req_in = ok_st | ok_key | ok_lock;
               if (ok_key) begin
                  out_code_in = scp_pkg::CmdKey;
               end else if (ok_lock) begin
                  out_code_in = scp_pkg::CmdLock;
               end else begin
                  out_code_in = scp_pkg::CmdStatus;
               end
               out_id_in  = (ok_st | ok_key | ok_lock) ? scp_pkg::DevIdW'(acc_ff) : '0;
               check_done = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         dv_ff      <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dv_ff      <= dv_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff     <= fill_in;
      rd_idx_ff   <= rd_idx_in;
      didx_ff     <= didx_in;
      match_ff    <= match_in;
      st_ok_ff    <= st_ok_in;
      key_ok_ff   <= key_ok_in;
      lock_ok_ff  <= lock_ok_in;
      acc_ff      <= acc_in;
      out_req_ff  <= out_req_in;
      out_code_ff <= out_code_in;
      out_id_ff   <= out_id_in;
   end

   assign rsp_empty         = ~out_vld_ff;
   assign rsp_request_valid = out_req_ff;
   assign rsp_command_code  = out_code_ff;
   assign rsp_device_id     = out_id_ff;

endmodule

[verif/scp_tb_pkg.sv]
// ---------------------------------------------------------------------------
// scp_tb_pkg: register indexes shared by the parser testbench files
// The stimulus writes the prefix registers by these indexes and the checker
// decodes the same writes to keep its own copy of the configuration.
// ---------------------------------------------------------------------------
package scp_tb_pkg;

   localparam logic RegPrefixChars  = 1'b0;
   localparam logic RegPrefixLength = 1'b1;

endpackage

[verif/scp_line_checker.sv]
// ---------------------------------------------------------------------------
// scp_line_checker: result checker for the console command-line parser
// Watches the byte, result and register ports, keeps its own line store and
// prefix settings, predicts the result of every accepted byte and compares
// each popped result with the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module scp_line_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic        rsp_request_valid,
   input  logic [1:0]  rsp_command_code,
   input  logic [63:0] rsp_device_id,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count,
   output int          request_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        request_valid;
      logic [1:0]  command_code;
      logic [63:0] device_id;
   } line_verdict_type;

   logic [7:0]       line_text [scp_pkg::LineBytes];
   int               line_len = 0;
   logic             line_dropped = 1'b0;
   logic [63:0]      prefix_reg = '0;
   logic [3:0]       prefix_len_reg = 4'd1;
   line_verdict_type expected_verdicts [$];
   int               fails = 0;
   int               checks = 0;
   int               requests = 0;

   function automatic logic tail_equals(input int at, input int count, input string word);
      if (count != word.len()) return 1'b0;
      for (int i = 0; i < count; i++) begin
         if (line_text[at + i] != word[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Checks the stored line for "<prefix> <hex id> <command>".
   function automatic line_verdict_type match_line();
      line_verdict_type v;
      int               n;
      int               word_at;
      logic [63:0]      acc;
      logic [7:0]       c;
      logic [7:0]       d;
      v.request_valid = 1'b0;
      v.command_code  = scp_pkg::CmdStatus;
      v.device_id     = '0;
      n = prefix_len_reg;
      if (n < 1) n = 1;
      if (n > 8) n = 8;
      word_at = n + 1 + scp_pkg::IdDigits + 1;
      if (line_len <= word_at) return v;
      for (int i = 0; i < n; i++) begin
         if (line_text[i] != prefix_reg[8*i +: 8]) return v;
      end
      if (line_text[n] != scp_pkg::ChSpace || line_text[word_at - 1] != scp_pkg::ChSpace) begin
         return v;
      end
      acc = '0;
      for (int i = 0; i < scp_pkg::IdDigits; i++) begin
         c = line_text[n + 1 + i];
         if (c >= scp_pkg::ChZero && c <= scp_pkg::ChNine) begin
            d = c - scp_pkg::ChZero;
         end else if (c >= scp_pkg::ChLowA && c <= scp_pkg::ChLowF) begin
            d = c - scp_pkg::ChLowA + 8'd10;
         end else begin
            return v;
         end
         acc = (acc << 4) | 64'(d[3:0]);
      end
      if (tail_equals(word_at, line_len - word_at, "STATUS")) begin
         v.command_code = scp_pkg::CmdStatus;
      end else if (tail_equals(word_at, line_len - word_at, "KEY")) begin
         v.command_code = scp_pkg::CmdKey;
      end else if (tail_equals(word_at, line_len - word_at, "LOCK")) begin
         v.command_code = scp_pkg::CmdLock;
      end else begin
         return v;
      end
      v.request_valid = 1'b1;
      v.device_id     = acc;
      return v;
   endfunction

   // Advances the line state by one console byte and returns its result.
   function automatic line_verdict_type console_byte_step(input logic [7:0] b);
      line_verdict_type v;
      v.request_valid = 1'b0;
      v.command_code  = scp_pkg::CmdStatus;
      v.device_id     = '0;
      if (b == scp_pkg::ChLf) begin
         if (!line_dropped) begin
            if (line_len > 0 && line_text[line_len - 1] == scp_pkg::ChCr) line_len--;
            v = match_line();
         end
         line_dropped = 1'b0;
         line_len     = 0;
      end else if (!line_dropped) begin
         if ((b < scp_pkg::ChSpace && b != scp_pkg::ChCr) || b > scp_pkg::ChMaxPrint ||
             line_len >= scp_pkg::LineBytes - 1) begin
            line_dropped = 1'b1;
         end else begin
            line_text[line_len] = b;
            line_len++;
         end
      end
      return v;
   endfunction

   always @(posedge clock) begin : monitor
      line_verdict_type want;
      if (reset) begin
         line_len       = 0;
         line_dropped   = 1'b0;
         prefix_reg     = '0;
         prefix_len_reg = 4'd1;
         expected_verdicts.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == scp_tb_pkg::RegPrefixChars) begin
               prefix_reg = csr_wdata;
            end else begin
               prefix_len_reg = csr_wdata[3:0];
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_verdicts.size() == 0) begin
               fails++;
               $error("result transaction with nothing expected: request_valid %0d, device_id %0h",
                      rsp_request_valid, rsp_device_id);
            end else begin
               want = expected_verdicts.pop_front();
               checks++;
               if (want.request_valid) requests++;
               if (rsp_request_valid !== want.request_valid) begin
                  fails++;
                  $error("request_valid: expected %0d, actual %0d",
                         want.request_valid, rsp_request_valid);
               end
               if (rsp_command_code !== want.command_code) begin
                  fails++;
                  $error("command_code: expected %0d, actual %0d",
                         want.command_code, rsp_command_code);
               end
               if (rsp_device_id !== want.device_id) begin
                  fails++;
                  $error("device_id: expected %h, actual %h", want.device_id, rsp_device_id);
               end
            end
         end
         if (req_push && !req_full) begin
            expected_verdicts.push_back(console_byte_step(req_rx_byte));
         end
      end
      fail_count    <= fails;
      pending_count <= expected_verdicts.size();
      checked_count <= checks;
      request_count <= requests;
   end

endmodule

[verif/setup_command_line_parser_top_tb.sv]
// ---------------------------------------------------------------------------
// setup_command_line_parser_top_tb: testbench for the console line parser
// Feeds console bytes - well-formed command lines with random identifiers,
// damaged lines, noise, overlong lines and bare line ends - under a series
// of prefix settings, with random idling on both sides, one long result
// stall, and drains between settings. A separate checker predicts and
// compares every result; this module only drives and gives the verdict.
// ---------------------------------------------------------------------------
module setup_command_line_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HoldCycles = 400;
   localparam int StallLimit = 5000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic [7:0]  req_rx_byte;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_request_valid;
   logic [1:0]  rsp_command_code;
   logic [63:0] rsp_device_id;
   logic        csr_wr_en;
   logic        csr_index;
   logic [63:0] csr_wdata;

   int fail_count;
   int pending_count;
   int checked_count;
   int request_count;

   logic [63:0] cur_prefix = '0;
   logic [3:0]  cur_len = 4'd1;
   logic [7:0]  line_buf [$];
   int          bytes_sent = 0;
   int          settings_used = 0;
   int          byte_goal = 0;
   int          idle_cycles = 0;
   bit          steady_window = 1'b0;
   bit          hold_off_request = 1'b0;
   bit          hold_off_done = 1'b0;

   setup_command_line_parser_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_rx_byte       (req_rx_byte),
      .req_full          (req_full),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_request_valid (rsp_request_valid),
      .rsp_command_code  (rsp_command_code),
      .rsp_device_id     (rsp_device_id),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   scp_line_checker line_checker (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_rx_byte       (req_rx_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_request_valid (rsp_request_valid),
      .rsp_command_code  (rsp_command_code),
      .rsp_device_id     (rsp_device_id),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count),
      .request_count     (request_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $error("no transaction for %0d cycles", StallLimit);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random pops, plus one long hold-off so the block backs up.
   initial begin
      forever begin
         if (hold_off_request && !hold_off_done) begin
            rsp_pop <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            rsp_pop <= steady_window || ($urandom_range(99) >= 16);
            @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      req_push    <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      bytes_sent++;
      if (!steady_window && $urandom_range(99) < 19) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_line();
      foreach (line_buf[i]) send_byte(line_buf[i]);
      line_buf.delete();
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [63:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_prefix(input logic [63:0] chars, input logic [3:0] len);
      drain();
      write_reg(scp_tb_pkg::RegPrefixChars, chars);
      write_reg(scp_tb_pkg::RegPrefixLength, 64'(len));
      cur_prefix = chars;
      cur_len    = len;
      settings_used++;
   endtask

   function automatic logic [63:0] random_prefix();
      logic [63:0] r;
      for (int i = 0; i < 8; i++) begin
         r[8*i +: 8] = 8'($urandom_range(scp_pkg::ChSpace, scp_pkg::ChMaxPrint));
      end
      return r;
   endfunction

   function automatic void add_printable(input int count);
      for (int i = 0; i < count; i++) begin
         line_buf.push_back(8'($urandom_range(scp_pkg::ChSpace, scp_pkg::ChMaxPrint)));
      end
   endfunction

   // Appends one complete command line built from the current prefix setting.
   function automatic void add_command(input logic [1:0] cmd, input logic [63:0] id,
                                       input bit with_cr);
      int         n;
      string      word;
      logic [3:0] nib;
      n = cur_len;
      if (n < 1) n = 1;
      if (n > 8) n = 8;
      for (int i = 0; i < n; i++) line_buf.push_back(cur_prefix[8*i +: 8]);
      line_buf.push_back(scp_pkg::ChSpace);
      for (int i = 0; i < scp_pkg::IdDigits; i++) begin
         nib = id[4*(scp_pkg::IdDigits - 1 - i) +: 4];
         line_buf.push_back((nib < 4'd10) ? 8'(scp_pkg::ChZero + nib) :
                                            8'(scp_pkg::ChLowA + nib - 4'd10));
      end
      line_buf.push_back(scp_pkg::ChSpace);
      case (cmd)
         scp_pkg::CmdStatus: word = "STATUS";
         scp_pkg::CmdKey:    word = "KEY";
         default:            word = "LOCK";
      endcase
      for (int i = 0; i < word.len(); i++) line_buf.push_back(word[i]);
      if (with_cr) line_buf.push_back(scp_pkg::ChCr);
      line_buf.push_back(scp_pkg::ChLf);
   endfunction

   // Damages one character of the pending line, never its final line feed.
   function automatic void mangle_line();
      int at;
      at = $urandom_range(line_buf.size() - 2);
      case ($urandom_range(2))
         0:       line_buf[at] = 8'($urandom_range(255));
         1:       line_buf.delete(at);
         default: line_buf.insert(at, 8'($urandom_range(scp_pkg::ChSpace, scp_pkg::ChMaxPrint)));
      endcase
   endfunction

   task automatic random_traffic(input int until_count);
      int pick;
      while (bytes_sent < until_count) begin
         pick = $urandom_range(99);
         if (pick < 62) begin
            add_command(2'($urandom_range(2)), {$urandom, $urandom}, 1'($urandom_range(1)));
            if ($urandom_range(3) == 0) mangle_line();
         end else if (pick < 72) begin
            repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(255)));
         end else if (pick < 82) begin
            add_printable($urandom_range(0, 40));
            line_buf.push_back(scp_pkg::ChLf);
         end else if (pick < 88) begin
            add_printable($urandom_range(58, 70));
            line_buf.push_back(scp_pkg::ChLf);
         end else begin
            if ($urandom_range(1)) line_buf.push_back(scp_pkg::ChCr);
            line_buf.push_back(scp_pkg::ChLf);
         end
         send_line();
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_push    <= 1'b0;
      req_rx_byte <= '0;
      csr_wr_en   <= 1'b0;
      csr_index   <= scp_tb_pkg::RegPrefixChars;
      csr_wdata   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The reset prefix is a single NUL, which no stored line can contain.
      line_buf = '{8'h78, scp_pkg::ChLf};
      send_line();

      set_prefix(64'h6261, 4'd2);
      add_command(scp_pkg::CmdStatus, 64'h0123456789abcdef, 1'b1);
      add_command(scp_pkg::CmdKey, 64'h0, 1'b0);
      add_command(scp_pkg::CmdLock, '1, 1'b1);
      send_line();
      // Empty lines, control bytes, DEL and high bytes; a discarded line
      // swallows everything up to its line feed.
      line_buf = '{scp_pkg::ChLf, scp_pkg::ChCr, scp_pkg::ChLf, 8'h61, 8'h01,
                   scp_pkg::ChMaxPrint, scp_pkg::ChLf, scp_pkg::ChSpace, 8'h7f,
                   scp_pkg::ChLf, 8'h80, 8'hff, scp_pkg::ChLf, 8'h00, scp_pkg::ChLf};
      send_line();
      // A CR that is not the last character stays in the line.
      add_command(scp_pkg::CmdKey, 64'hfedcba9876543210, 1'b1);
      line_buf.insert(line_buf.size() - 2, scp_pkg::ChCr);
      send_line();
      // The longest line the store keeps, then one character too many.
      add_printable(scp_pkg::LineBytes - 1);
      line_buf.push_back(scp_pkg::ChLf);
      add_printable(scp_pkg::LineBytes);
      line_buf.push_back(scp_pkg::ChLf);
      send_line();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               set_prefix(random_prefix(), 4'd8);
               hold_off_request = 1'b1;
               byte_goal = bytes_sent + 500;
            end
            1: begin
               set_prefix(random_prefix(), 4'd0);
               steady_window = 1'b1;
               byte_goal = bytes_sent + 400;
            end
            2: begin
               steady_window = 1'b0;
               set_prefix(random_prefix(), 4'd15);
               byte_goal = bytes_sent + 400;
            end
            3: begin
               set_prefix('1, 4'd8);
               byte_goal = bytes_sent + 150;
            end
            4: begin
               set_prefix('0, 4'd1);
               byte_goal = bytes_sent + 150;
            end
            default: begin
               set_prefix(random_prefix(), 4'($urandom_range(1, 7)));
               byte_goal = bytes_sent + 400;
            end
         endcase
         random_traffic(byte_goal);
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Checked %0d results from %0d console bytes under %0d prefix settings,",
               checked_count, bytes_sent, settings_used);
      $display("with %0d command lines recognized and one long result-side stall.",
               request_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
